FILE: rtl/rope_pkg.sv
`default_nettype none
package rope_pkg;

  localparam int unsigned MaxTokens  = 4096;
  localparam int unsigned MaxHeads   = 128;
  localparam int unsigned MaxHalfDim = 128;
  localparam int unsigned PaddrW     = 4;

  typedef enum logic [1:0] {
    RegQueryHeads = 2'd0,
    RegKvHeads    = 2'd1,
    RegHalfDim    = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    TgtQuery = 2'd0,
    TgtKey   = 2'd1,
    TgtNone  = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    FpFinite = 2'd0,
    FpZero   = 2'd1,
    FpInf    = 2'd2,
    FpNan    = 2'd3
  } fp_class_e;

  typedef struct packed {
    logic [7:0] query_heads;
    logic [7:0] kv_heads;
    logic [7:0] pair_cnt;
  } cfg_t;

  // leading zero count, 32 for an all-zero word
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  // sig has its msb set; expo is the biased exponent of that msb.
  // Round to nearest even into fp32, subnormal results included.
  function automatic logic [31:0] round_pack(input logic sign, input logic [31:0] sig,
                                             input logic signed [10:0] expo);
    logic [10:0] rshift;
    logic [5:0]  sh;
    logic [31:0] sh_sig;
    logic        lost;
    logic [23:0] keep;
    logic        guard;
    logic        sticky;
    logic        inc;
    logic [7:0]  efield;
    logic [30:0] packed_v;
    rshift = '0;
    if (expo >= 11'sd255) return {sign, 8'hFF, 23'd0};
    if (expo >= 11'sd1) begin
      sh     = '0;
      efield = expo[7:0];
    end else begin
      rshift = 11'(11'sd1 - expo);
      sh     = (rshift > 11'd32) ? 6'd32 : rshift[5:0];
      efield = '0;
    end
    sh_sig   = sig >> sh;
    lost     = |(sig & ~({32{1'b1}} << sh));
    keep     = sh_sig[31:8];
    guard    = sh_sig[7];
    sticky   = (|sh_sig[6:0]) | lost;
    inc      = guard & (sticky | keep[0]);
    // a carry out of the mantissa bumps the exponent, up to infinity
    packed_v = {efield, keep[22:0]} + {30'd0, inc};
    return {sign, packed_v};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rope_fmul.sv
`default_nettype none
// bf16 x fp32 product rounded to fp32, three stages: multiply, normalize, round
module rope_fmul (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] a_i,
  input  wire logic [31:0] c_i,
  output logic      [31:0] p_o
);

  logic                  a_nan, a_inf, a_zero, c_nan, c_inf, c_zero;
  logic [7:0]            ea_eff, ec_eff;
  rope_pkg::fp_class_e   cls_d;

  logic                  sign1_q, sign2_q;
  rope_pkg::fp_class_e   cls1_q, cls2_q;
  logic [31:0]           sig1_q, sig2_q;
  logic [8:0]            esum1_q;
  logic signed [10:0]    exp2_q;
  logic [31:0]           p_q;
  logic [5:0]            lz;

  always_comb begin
    a_nan  = (a_i[14:7] == 8'hFF) && (a_i[6:0] != '0);
    a_inf  = (a_i[14:7] == 8'hFF) && (a_i[6:0] == '0);
    a_zero = (a_i[14:0] == '0);
    c_nan  = (c_i[30:23] == 8'hFF) && (c_i[22:0] != '0);
    c_inf  = (c_i[30:23] == 8'hFF) && (c_i[22:0] == '0);
    c_zero = (c_i[30:0] == '0);
    ea_eff = (a_i[14:7] == '0) ? 8'd1 : a_i[14:7];
    ec_eff = (c_i[30:23] == '0) ? 8'd1 : c_i[30:23];
    if (a_nan || c_nan || (a_inf && c_zero) || (a_zero && c_inf)) begin
      cls_d = rope_pkg::FpNan;
    end else if (a_inf || c_inf) begin
      cls_d = rope_pkg::FpInf;
    end else if (a_zero || c_zero) begin
      cls_d = rope_pkg::FpZero;
    end else begin
      cls_d = rope_pkg::FpFinite;
    end
  end

  assign lz = rope_pkg::lzc32(sig1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign1_q <= a_i[15] ^ c_i[31];
      cls1_q  <= cls_d;
      sig1_q  <= 32'({(a_i[14:7] != '0), a_i[6:0]}) * 32'({(c_i[30:23] != '0), c_i[22:0]});
      esum1_q <= {1'b0, ea_eff} + {1'b0, ec_eff};

      sign2_q <= sign1_q;
      cls2_q  <= cls1_q;
      sig2_q  <= sig1_q << lz[4:0];
      exp2_q  <= $signed({2'b00, esum1_q}) - 11'sd126 - $signed({5'd0, lz});

      unique case (cls2_q)
        rope_pkg::FpNan:    p_q <= 32'h7FC0_0000;
        rope_pkg::FpInf:    p_q <= {sign2_q, 8'hFF, 23'd0};
        rope_pkg::FpZero:   p_q <= {sign2_q, 31'd0};
        rope_pkg::FpFinite: p_q <= rope_pkg::round_pack(sign2_q, sig2_q, exp2_q);
        default:            p_q <= 32'h7FC0_0000;
      endcase
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

FILE: rtl/rope_fadd.sv
`default_nettype none
// fp32 add rounded to fp32, then to bf16; stages: align/add, normalize, round
module rope_fadd (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  output logic      [15:0] z_o
);

  logic                x_nan, x_inf, y_nan, y_inf, swap, sub;
  logic [31:0]         big, sml;
  logic [7:0]          eb_eff, es_eff, dexp;
  logic [4:0]          ds;
  logic [26:0]         sig_b, sig_s, s_sh, s_al;
  logic                st;
  rope_pkg::fp_class_e cls_d;
  logic                sign_d;

  logic                sign4_q, zsign4_q, sign5_q;
  rope_pkg::fp_class_e cls4_q, cls5_q;
  logic [27:0]         sum4_q;
  logic [7:0]          eb4_q;
  logic [31:0]         sig5_q;
  logic signed [10:0]  exp5_q;
  logic [15:0]         z_q;
  logic [5:0]          lz;
  logic [31:0]         fp;

  function automatic logic [15:0] to_bf16(input logic [31:0] u);
    logic [31:0] r;
    r = u + 32'h0000_7FFF + {31'd0, u[16]};
    return r[31:16];
  endfunction

  always_comb begin
    x_nan  = (x_i[30:23] == 8'hFF) && (x_i[22:0] != '0);
    x_inf  = (x_i[30:23] == 8'hFF) && (x_i[22:0] == '0);
    y_nan  = (y_i[30:23] == 8'hFF) && (y_i[22:0] != '0);
    y_inf  = (y_i[30:23] == 8'hFF) && (y_i[22:0] == '0);
    swap   = y_i[30:0] > x_i[30:0];
    big    = swap ? y_i : x_i;
    sml    = swap ? x_i : y_i;
    sub    = big[31] ^ sml[31];
    eb_eff = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    dexp   = eb_eff - es_eff;
    ds     = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
    sig_b  = {(big[30:23] != '0), big[22:0], 3'b000};
    sig_s  = {(sml[30:23] != '0), sml[22:0], 3'b000};
    s_sh   = sig_s >> ds;
    st     = |(sig_s & ~({27{1'b1}} << ds));
    s_al   = {s_sh[26:1], s_sh[0] | st};
    sign_d = big[31];
    if (x_nan || y_nan || (x_inf && y_inf && (x_i[31] != y_i[31]))) begin
      cls_d = rope_pkg::FpNan;
    end else if (x_inf || y_inf) begin
      cls_d  = rope_pkg::FpInf;
      sign_d = x_inf ? x_i[31] : y_i[31];
    end else begin
      cls_d = rope_pkg::FpFinite;
    end
  end

  assign lz = rope_pkg::lzc32({sum4_q, 4'b0000});
  assign fp = rope_pkg::round_pack(sign5_q, sig5_q, exp5_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls4_q   <= cls_d;
      sign4_q  <= sign_d;
      // exact zero: +0 unless both operands are -0
      zsign4_q <= x_i[31] & y_i[31];
      sum4_q   <= sub ? ({1'b0, sig_b} - {1'b0, s_al}) : ({1'b0, sig_b} + {1'b0, s_al});
      eb4_q    <= eb_eff;

      if ((cls4_q == rope_pkg::FpFinite) && (sum4_q == '0)) begin
        cls5_q  <= rope_pkg::FpZero;
        sign5_q <= zsign4_q;
      end else begin
        cls5_q  <= cls4_q;
        sign5_q <= sign4_q;
      end
      sig5_q <= {sum4_q, 4'b0000} << lz[4:0];
      exp5_q <= $signed({3'b000, eb4_q}) + 11'sd1 - $signed({5'd0, lz});

      unique case (cls5_q)
        rope_pkg::FpNan:    z_q <= 16'h7FC0;
        rope_pkg::FpInf:    z_q <= {sign5_q, 15'h7F80};
        rope_pkg::FpZero:   z_q <= {sign5_q, 15'd0};
        rope_pkg::FpFinite: z_q <= to_bf16(fp);
        default:            z_q <= 16'h7FC0;
      endcase
    end
  end

  assign z_o = z_q;

endmodule
`default_nettype wire

FILE: rtl/rope_addr.sv
`default_nettype none
// head classification and flat element addresses, six stages to match the datapath
module rope_addr (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire rope_pkg::cfg_t     cfg_i,
  input  wire logic        [11:0] token_i,
  input  wire logic        [7:0]  head_i,
  input  wire logic        [6:0]  pair_i,
  output rope_pkg::target_e       tgt_o,
  output logic             [26:0] first_o,
  output logic             [26:0] second_o
);

  logic              oor, is_q;
  logic [7:0]        nh, loc;
  rope_pkg::target_e tgt_d;

  rope_pkg::target_e tgt1_q, tgt2_q, tgt3_q, tgt4_q, tgt5_q, tgt6_q;
  logic [19:0]       th1_q;
  logic [7:0]        loc1_q;
  logic [6:0]        pair1_q, pair2_q, pair3_q;
  logic [20:0]       base2_q;
  logic [26:0]       prod3_q;
  logic [26:0]       f4_q, s4_q, f5_q, s5_q, f6_q, s6_q;
  logic [29:0]       full;

  always_comb begin
    oor  = ({1'b0, token_i} >= 13'(rope_pkg::MaxTokens)) ||
           ({1'b0, head_i} >= ({1'b0, cfg_i.query_heads} + {1'b0, cfg_i.kv_heads}));
    is_q = head_i < cfg_i.query_heads;
    nh   = is_q ? cfg_i.query_heads : cfg_i.kv_heads;
    loc  = is_q ? head_i : (head_i - cfg_i.query_heads);
    if (oor) begin
      tgt_d = rope_pkg::TgtNone;
    end else if (is_q) begin
      tgt_d = rope_pkg::TgtQuery;
    end else begin
      tgt_d = rope_pkg::TgtKey;
    end
  end

  assign full = 30'(base2_q) * 30'({cfg_i.pair_cnt, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tgt1_q  <= tgt_d;
      th1_q   <= 20'(token_i) * 20'(nh);
      loc1_q  <= loc;
      pair1_q <= pair_i;

      tgt2_q  <= tgt1_q;
      base2_q <= {1'b0, th1_q} + 21'(loc1_q);
      pair2_q <= pair1_q;

      tgt3_q  <= tgt2_q;
      prod3_q <= full[26:0];
      pair3_q <= pair2_q;

      tgt4_q  <= tgt3_q;
      f4_q    <= prod3_q + 27'(pair3_q);
      s4_q    <= prod3_q + 27'(pair3_q) + 27'(cfg_i.pair_cnt);

      tgt5_q  <= tgt4_q;
      f5_q    <= f4_q;
      s5_q    <= s4_q;

      tgt6_q  <= tgt5_q;
      f6_q    <= (tgt5_q == rope_pkg::TgtNone) ? '0 : f5_q;
      s6_q    <= (tgt5_q == rope_pkg::TgtNone) ? '0 : s5_q;
    end
  end

  assign tgt_o    = tgt6_q;
  assign first_o  = f6_q;
  assign second_o = s6_q;

endmodule
`default_nettype wire

FILE: rtl/rope_bf16_pair_rotator_top.sv
`default_nettype none
// Rotary position embedding for one bf16 element pair per transaction: returns
// bf16 a*c-b*s and a*s+b*c (each product and sum rounded to fp32, then RNE to
// bf16, NaN as 0x7FC0), the head kind and both flat element addresses; an
// out-of-range head gives target 2 and zeros. Six-stage pipeline (fp32
// multiply 3 stages, fp32 add 3 stages), one transaction per cycle while the
// output is not stalled. A stall on the output freezes the whole pipeline.
// Registers over APB at 0x0 query heads, 0x4 key heads, 0x8 pairs per head;
// write only while no transaction is in flight.
module rope_bf16_pair_rotator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [rope_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] token_index_i,
  input  wire logic [7:0]  head_index_i,
  input  wire logic [6:0]  pair_index_i,
  input  wire logic [15:0] first_in_i,
  input  wire logic [15:0] second_in_i,
  input  wire logic [31:0] cos_value_i,
  input  wire logic [31:0] sin_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       target_o,
  output logic [26:0]      first_address_o,
  output logic [26:0]      second_address_o,
  output logic [15:0]      first_out_o,
  output logic [15:0]      second_out_o
);

  rope_pkg::cfg_t     cfg_q;
  rope_pkg::reg_idx_e idx;
  logic [7:0]         v, sat_heads, sat_hd;
  logic               en;
  logic [5:0]         vld_q;
  logic [31:0]        ac, bs, as_p, bc;
  logic [15:0]        r0, r1;
  rope_pkg::target_e  tgt;

  assign idx       = rope_pkg::reg_idx_e'(paddr[3:2]);
  assign v         = pwdata[7:0];
  assign sat_heads = (v > 8'(rope_pkg::MaxHeads)) ? 8'(rope_pkg::MaxHeads) : v;
  assign sat_hd    = (v == '0) ? 8'd1 :
                     ((v > 8'(rope_pkg::MaxHalfDim)) ? 8'(rope_pkg::MaxHalfDim) : v);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.query_heads <= 8'd32;
      cfg_q.kv_heads    <= 8'd8;
      cfg_q.pair_cnt    <= 8'd64;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        rope_pkg::RegQueryHeads: cfg_q.query_heads <= sat_heads;
        rope_pkg::RegKvHeads:    cfg_q.kv_heads    <= sat_heads;
        rope_pkg::RegHalfDim:    cfg_q.pair_cnt    <= sat_hd;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rope_pkg::RegQueryHeads: prdata = {24'd0, cfg_q.query_heads};
      rope_pkg::RegKvHeads:    prdata = {24'd0, cfg_q.kv_heads};
      rope_pkg::RegHalfDim:    prdata = {24'd0, cfg_q.pair_cnt};
      default:                 prdata = '0;
    endcase
  end

  assign en         = ~(vld_q[5] & out_stall_i);
  assign in_stall_o = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  rope_fmul u_mul_ac (.clk_i, .en_i(en), .a_i(first_in_i),  .c_i(cos_value_i), .p_o(ac));
  rope_fmul u_mul_bs (.clk_i, .en_i(en), .a_i(second_in_i), .c_i(sin_value_i), .p_o(bs));
  rope_fmul u_mul_as (.clk_i, .en_i(en), .a_i(first_in_i),  .c_i(sin_value_i), .p_o(as_p));
  rope_fmul u_mul_bc (.clk_i, .en_i(en), .a_i(second_in_i), .c_i(cos_value_i), .p_o(bc));

  // subtraction as addition of the negated product
  rope_fadd u_add_r0 (.clk_i, .en_i(en), .x_i(ac), .y_i({~bs[31], bs[30:0]}), .z_o(r0));
  rope_fadd u_add_r1 (.clk_i, .en_i(en), .x_i(as_p), .y_i(bc), .z_o(r1));

  rope_addr u_addr (
    .clk_i,
    .en_i     (en),
    .cfg_i    (cfg_q),
    .token_i  (token_index_i),
    .head_i   (head_index_i),
    .pair_i   (pair_index_i),
    .tgt_o    (tgt),
    .first_o  (first_address_o),
    .second_o (second_address_o)
  );

  assign out_valid_o  = vld_q[5];
  assign target_o     = tgt;
  assign first_out_o  = (tgt == rope_pkg::TgtNone) ? 16'd0 : r0;
  assign second_out_o = (tgt == rope_pkg::TgtNone) ? 16'd0 : r1;

endmodule
`default_nettype wire
